// ----- src/sparse_tensor_index_remap_assert.svh -----
// assertion helpers used by sparse_tensor_index_remap.sv
`ifndef SPARSE_TENSOR_INDEX_REMAP_ASSERT_SVH
`define SPARSE_TENSOR_INDEX_REMAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stir check failed");

// next-cycle implication, checked out of reset
`define STIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stir check failed");

`endif

// ----- src/stir_pkg.sv -----
package stir_pkg;

    localparam int LANES  = 4;
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;

    typedef logic [CIDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]        t_kind;

    // register indexes
    localparam t_cfg_idx CFG_DIMS      = 3'd0;
    localparam t_cfg_idx CFG_KINDS     = 3'd1;
    localparam t_cfg_idx CFG_ATTRS_LOW = 3'd2;
    localparam t_cfg_idx CFG_ATTRS_HI  = 3'd3;
    localparam t_cfg_idx CFG_SCALE     = 3'd4;
    localparam t_cfg_idx CFG_DEGREE    = 3'd5;

    // index kinds, the fourth code behaves as open
    localparam t_kind KIND_OPEN  = 2'd0;
    localparam t_kind KIND_FIXED = 2'd1;
    localparam t_kind KIND_TRACE = 2'd2;

    localparam logic [31:0] DIMS_RST   = 32'h0101_0101;
    localparam logic [31:0] SCALE_RST  = 32'h0001_0000;
    localparam logic [2:0]  DEGREE_RST = 3'd1;

endpackage

// ----- src/stir_in_if.sv -----
interface stir_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] entry_position;
    logic signed [31:0] entry_value;

    modport source (output valid, entry_position, entry_value, input ready);
    modport sink   (input valid, entry_position, entry_value, output ready);
endinterface

// ----- src/stir_out_if.sv -----
interface stir_out_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [31:0] out_position;
    logic signed [31:0] scaled_value;

    modport source (output valid, keep, out_position, scaled_value, input ready);
    modport sink   (input valid, keep, out_position, scaled_value, output ready);
endinterface

// ----- src/stir_div.sv -----
// pipelined restoring divide by an 8-bit divisor, four quotient bits per stage
module stir_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [W-1:0]      i_dividend,
    input  logic [7:0]        i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [W-1:0]      o_quot,
    output logic [7:0]        o_rem,
    output logic [SIDE_W-1:0] o_side
);
    localparam int NS = (W + 3) / 4;

    logic              r_v [NS];
    logic [W-1:0]      r_n [NS];
    logic [7:0]        r_r [NS];
    logic [SIDE_W-1:0] r_s [NS];
    logic [NS:0]       w_rdy;

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic              w_v_in;
        logic [W-1:0]      w_n_in;
        logic [7:0]        w_r_in;
        logic [SIDE_W-1:0] w_s_in;
        logic [W-1:0]      n_n;
        logic [7:0]        n_r;

        if (s == 0) begin : g_first
            assign w_v_in = i_valid;
            assign w_n_in = i_dividend;
            assign w_r_in = '0;
            assign w_s_in = i_side;
        end else begin : g_rest
            assign w_v_in = r_v[s-1];
            assign w_n_in = r_n[s-1];
            assign w_r_in = r_r[s-1];
            assign w_s_in = r_s[s-1];
        end

        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];

        always_comb begin
            logic [8:0] t;
            logic       q;
            n_n = w_n_in;
            n_r = w_r_in;
            for (int k = 0; k < 4; k++) begin
                if (s * 4 + k < W) begin
                    t = {n_r, n_n[W-1]};
                    q = (t >= {1'b0, i_divisor});
                    if (q) begin
                        t = t - {1'b0, i_divisor};
                    end
                    n_r = t[7:0];
                    n_n = {n_n[W-2:0], q};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_v[s] <= w_v_in;
            end
            if (w_rdy[s]) begin
                r_n[s] <= n_n;
                r_r[s] <= n_r;
                r_s[s] <= w_s_in;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quot  = r_n[NS-1];
    assign o_rem   = r_r[NS-1];
    assign o_side  = r_s[NS-1];
endmodule

// ----- src/sparse_tensor_index_remap.sv -----
// channel    | dir | payload                                | handshake
// i_entry    | in  | entry_position 32u, entry_value 32s    | valid/ready
// o_result   | out | keep 1, out_position 32u, scaled_value | valid/ready
// i_cfg_*    | in  | idx 3, data 64                         | write enable only
//
// one word per cycle sustained while o_result is ready; each word passes four
// chained divider pipelines (four quotient bits per stage), then product and
// sum/round stages. reset is synchronous active low and clears valid bits and
// config registers. stalls back up stage by stage; an empty stage stays open.
`include "sparse_tensor_index_remap_assert.svh"
module sparse_tensor_index_remap #(
    parameter int MAX_DEGREE    = 4,
    parameter int POSITION_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    stir_in_if.sink                     i_entry,
    stir_out_if.source                  o_result,
    input  logic                        i_cfg_we,
    input  stir_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [stir_pkg::CFG_W-1:0]  i_cfg_data
);
    // effective position width: the result field is 32 bits anyway
    localparam int PW     = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam int DEG_MX = (MAX_DEGREE < stir_pkg::LANES) ? MAX_DEGREE : stir_pkg::LANES;
    localparam int SIDE_W = 64;

    // configuration registers
    logic [31:0]        r_dims;
    logic [7:0]         r_kinds;
    logic [63:0]        r_attr_lo;
    logic [63:0]        r_attr_hi;
    logic signed [31:0] r_scale;
    logic [2:0]         r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= stir_pkg::DIMS_RST;
            r_kinds   <= '0;
            r_attr_lo <= '0;
            r_attr_hi <= '0;
            r_scale   <= stir_pkg::SCALE_RST;
            r_deg     <= stir_pkg::DEGREE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stir_pkg::CFG_DIMS:      r_dims    <= i_cfg_data[31:0];
                stir_pkg::CFG_KINDS:     r_kinds   <= i_cfg_data[7:0];
                stir_pkg::CFG_ATTRS_LOW: r_attr_lo <= i_cfg_data;
                stir_pkg::CFG_ATTRS_HI:  r_attr_hi <= i_cfg_data;
                stir_pkg::CFG_SCALE:     r_scale   <= i_cfg_data[31:0];
                stir_pkg::CFG_DEGREE:    r_deg     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // degree clamp, per-lane divisor (unused lanes divide by one)
    logic [2:0]  w_deg;
    logic [7:0]  w_dim  [stir_pkg::LANES];
    logic [31:0] w_attr [stir_pkg::LANES];

    assign w_deg = (r_deg > 3'(DEG_MX)) ? 3'(DEG_MX) : r_deg;

    always_comb begin
        for (int i = 0; i < stir_pkg::LANES; i++) begin
            w_dim[i] = r_dims[8*(3-i) +: 8];
            if (w_dim[i] == 8'd0 || 3'(i) >= w_deg) begin
                w_dim[i] = 8'd1;
            end
            w_attr[i] = (i < 2) ? r_attr_lo[32*(i & 1) +: 32] : r_attr_hi[32*(i & 1) +: 32];
        end
    end

    // divider chain: lane 3 first, each remainder is that lane's coordinate
    // side word: value in upper half, coordinates in lower half, lane i at 8i
    logic              w_dv   [5];
    logic              w_dr   [5];
    logic [PW-1:0]     w_dq   [5];
    logic [SIDE_W-1:0] w_ds   [5];
    logic [7:0]        w_drem [4];
    logic [SIDE_W-1:0] w_dso  [4];

    assign w_dv[0]        = i_entry.valid;
    assign i_entry.ready  = w_dr[0];
    assign w_dq[0]        = i_entry.entry_position[PW-1:0];
    assign w_ds[0]        = {i_entry.entry_value, 32'd0};

    for (genvar j = 0; j < stir_pkg::LANES; j++) begin : g_div
        localparam int LN = stir_pkg::LANES - 1 - j;
        stir_div #(.W(PW), .SIDE_W(SIDE_W)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_dv[j]),
            .o_ready    (w_dr[j]),
            .i_dividend (w_dq[j]),
            .i_divisor  (w_dim[LN]),
            .i_side     (w_ds[j]),
            .o_valid    (w_dv[j+1]),
            .i_ready    (w_dr[j+1]),
            .o_quot     (w_dq[j+1]),
            .o_rem      (w_drem[j]),
            .o_side     (w_dso[j])
        );
        always_comb begin
            w_ds[j+1] = w_dso[j];
            w_ds[j+1][8*LN +: 8] = w_drem[j];
        end
    end

    // stage a: lane products, keep check, value times scale
    logic                   w_a_rdy;
    logic                   w_b_rdy;
    logic                   r_a_v;
    logic                   r_a_keep;
    logic [PW-1:0]          r_a_prod [stir_pkg::LANES];
    logic signed [63:0]     r_a_mul;
    logic                   n_a_keep;
    logic [PW-1:0]          n_a_prod [stir_pkg::LANES];
    logic [7:0]             w_coord  [stir_pkg::LANES];

    assign w_a_rdy  = !r_a_v || w_b_rdy;
    assign w_dr[4]  = w_a_rdy;

    always_comb begin
        logic [7:0]  partner;
        logic [39:0] prod;
        stir_pkg::t_kind kind;
        for (int i = 0; i < stir_pkg::LANES; i++) begin
            w_coord[i] = w_ds[4][8*i +: 8];
        end
        n_a_keep = 1'b1;
        for (int i = 0; i < stir_pkg::LANES; i++) begin
            kind        = r_kinds[2*i +: 2];
            partner     = (w_attr[i] < 32'(w_deg)) ? w_coord[w_attr[i][1:0]] : 8'd0;
            prod        = 40'(w_coord[i]) * 40'(w_attr[i]);
            n_a_prod[i] = '0;
            if (3'(i) < w_deg) begin
                case (kind)
                    stir_pkg::KIND_FIXED: begin
                        if (32'(w_coord[i]) != w_attr[i]) n_a_keep = 1'b0;
                    end
                    stir_pkg::KIND_TRACE: begin
                        if (w_coord[i] != partner) n_a_keep = 1'b0;
                    end
                    default: begin
                        n_a_prod[i] = prod[PW-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_v <= w_dv[4];
        end
        if (w_a_rdy) begin
            r_a_keep <= n_a_keep;
            r_a_prod <= n_a_prod;
            r_a_mul  <= 64'($signed(w_ds[4][63:32])) * 64'(r_scale);
        end
    end

    // stage b: position sum, round to nearest (ties up), saturate, zero on drop
    logic               r_b_v;
    logic               r_b_keep;
    logic [31:0]        r_b_pos;
    logic signed [31:0] r_b_val;
    logic [PW-1:0]      n_b_sum;
    logic signed [31:0] n_b_val;

    assign w_b_rdy = !r_b_v || o_result.ready;

    always_comb begin
        logic signed [63:0] p;
        logic signed [47:0] q;
        p = r_a_mul + 64'sd32768;
        q = 48'(p >>> 16);
        if (q > 48'sh0000_7FFF_FFFF) begin
            n_b_val = 32'sh7FFF_FFFF;
        end else if (q < -48'sh0000_8000_0000) begin
            n_b_val = 32'sh8000_0000;
        end else begin
            n_b_val = q[31:0];
        end
        n_b_sum = r_a_prod[0] + r_a_prod[1] + r_a_prod[2] + r_a_prod[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_v <= r_a_v;
        end
        if (w_b_rdy) begin
            r_b_keep <= r_a_keep;
            r_b_pos  <= r_a_keep ? 32'(n_b_sum) : 32'd0;
            r_b_val  <= r_a_keep ? n_b_val : 32'sd0;
        end
    end

    assign o_result.valid        = r_b_v;
    assign o_result.keep         = r_b_keep;
    assign o_result.out_position = r_b_pos;
    assign o_result.scaled_value = r_b_val;

    // a dropped word carries zero position and value
    `STIR_ASSERT_NOW(a_drop_zero, r_b_v && !r_b_keep, r_b_pos == 32'd0 && r_b_val == 32'sd0)
    // stage a never loses a word it could not pass on
    `STIR_ASSERT_NEXT(a_hold_a, r_a_v && !w_b_rdy, r_a_v)
    // a word leaving the divider chain lands in stage a
    `STIR_ASSERT_NEXT(a_fill_a, w_dv[4] && w_a_rdy, r_a_v)
endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word
    typedef struct packed {
        logic        keep;
        logic [31:0] out_position;
        logic [31:0] scaled_value;
    } t_remap;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    stir_pkg::t_cfg_idx i_cfg_idx;
    logic [stir_pkg::CFG_W-1:0] i_cfg_data;

    stir_in_if  entry_ch ();
    stir_out_if result_ch ();

    sparse_tensor_index_remap dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (entry_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the register file
    logic [31:0] dims_q;
    logic [7:0]  kinds_q;
    logic [63:0] attrs_lo_q;
    logic [63:0] attrs_hi_q;
    logic [31:0] scale_q;
    logic [2:0]  degree_q;

    t_remap      remap_queue[$];
    int unsigned error_count;
    int unsigned result_count;
    int unsigned kept_count;
    int unsigned entries_sent;
    longint unsigned cycle_count = 0;
    bit          recv_hold;

    localparam longint unsigned CYCLE_LIMIT = 200000;
    // divider chain plus product and round stages
    localparam int LATENCY = 4 * 8 + 2;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // saturated, round half up, q16.16 product
    function automatic logic [31:0] scale_q16(input logic signed [31:0] val,
                                              input logic signed [31:0] fac);
        logic signed [63:0] prod;
        logic signed [63:0] quo;
        prod = 64'(val) * 64'(fac) + 64'sd32768;
        quo  = prod >>> 16;
        if (quo > 64'sd2147483647) quo = 64'sd2147483647;
        if (quo < -64'sd2147483648) quo = -64'sd2147483648;
        return quo[31:0];
    endfunction

    // split the position, apply open/fixed/trace per index
    function automatic t_remap remap_entry(input logic [31:0] pos,
                                           input logic signed [31:0] val);
        logic [63:0] coord[stir_pkg::LANES];
        logic [63:0] div;
        logic [63:0] dim;
        logic [63:0] attr;
        logic [63:0] other;
        logic [31:0] newpos;
        stir_pkg::t_kind kind;
        int          deg;
        bit          keep;
        t_remap      res;
        deg    = (degree_q > 4) ? 4 : int'(degree_q);
        div    = 1;
        newpos = 0;
        keep   = 1'b1;
        for (int i = 0; i < stir_pkg::LANES; i++) coord[i] = 0;
        for (int i = deg - 1; i >= 0; i--) begin
            dim = 64'(dims_q[8*(3-i) +: 8]);
            if (dim == 0) dim = 1;
            coord[i] = (64'(pos) / div) % dim;
            div = div * dim;
        end
        for (int i = 0; i < deg; i++) begin
            kind = kinds_q[2*i +: 2];
            attr = (i < 2) ? 64'(attrs_lo_q[32*(i%2) +: 32]) : 64'(attrs_hi_q[32*(i%2) +: 32]);
            if (kind == stir_pkg::KIND_FIXED) begin
                if (coord[i] != attr) keep = 1'b0;
            end else if (kind == stir_pkg::KIND_TRACE) begin
                other = (attr < 64'(deg)) ? coord[attr[1:0]] : 64'd0;
                if (coord[i] != other) keep = 1'b0;
            end else begin
                newpos = newpos + 32'(coord[i] * attr);
            end
        end
        res = '0;
        if (keep) begin
            res.keep = 1'b1;
            res.out_position = newpos;
            res.scaled_value = scale_q16(val, scale_q);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, result_count);
    endtask

    // register write, only called while idle; enable dropped by the caller
    task automatic write_reg(input stir_pkg::t_cfg_idx idx,
                             input logic [stir_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            stir_pkg::CFG_DIMS:      dims_q     = data[31:0];
            stir_pkg::CFG_KINDS:     kinds_q    = data[7:0];
            stir_pkg::CFG_ATTRS_LOW: attrs_lo_q = data;
            stir_pkg::CFG_ATTRS_HI:  attrs_hi_q = data;
            stir_pkg::CFG_SCALE:     scale_q    = data[31:0];
            stir_pkg::CFG_DEGREE:    degree_q   = data[2:0];
            default: ;
        endcase
    endtask

    // wait for all words back, then let the pipe drain
    task automatic drain();
        entry_ch.valid <= 1'b0;
        while (remap_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] dims, input logic [7:0] kinds,
                             input logic [63:0] lo, input logic [63:0] hi,
                             input logic [31:0] scale, input logic [2:0] deg);
        drain();
        write_reg(stir_pkg::CFG_DIMS, 64'(dims));
        write_reg(stir_pkg::CFG_KINDS, 64'(kinds));
        write_reg(stir_pkg::CFG_ATTRS_LOW, lo);
        write_reg(stir_pkg::CFG_ATTRS_HI, hi);
        write_reg(stir_pkg::CFG_SCALE, 64'(scale));
        write_reg(stir_pkg::CFG_DEGREE, 64'(deg));
        i_cfg_we <= 1'b0;
    endtask

    // send one entry word; predict at acceptance, valid stays up for the next
    task automatic send_entry(input logic [31:0] pos, input logic [31:0] val);
        entry_ch.valid          <= 1'b1;
        entry_ch.entry_position <= pos;
        entry_ch.entry_value    <= val;
        @(posedge i_clk);
        while (!entry_ch.ready) @(posedge i_clk);
        remap_queue.push_back(remap_entry(pos, val));
        entries_sent++;
    endtask

    // bursty sender: random gaps between bursts
    task automatic send_random(input int count, input bit small_pos);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) begin
                    entry_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            burst--;
            send_entry(small_pos ? $urandom_range(0, 300) : $urandom(), $urandom());
        end
    endtask

    // receiver: stall pattern with calm stretches
    always @(posedge i_clk) begin
        if (cycle_count % 512 < 128) result_ch.ready <= 1'b1;
        else result_ch.ready <= ($urandom_range(0, 3) != 0) ^ recv_hold;
    end

    // checker
    always @(posedge i_clk) begin
        t_remap want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            result_count++;
            if (remap_queue.size() == 0) begin
                report_mismatch("unexpected word", result_ch.out_position, 32'd0);
            end else begin
                want = remap_queue.pop_front();
                if (result_ch.keep !== want.keep)
                    report_mismatch("keep", 32'(result_ch.keep), 32'(want.keep));
                if (result_ch.out_position !== want.out_position)
                    report_mismatch("out_position", result_ch.out_position, want.out_position);
                if (result_ch.scaled_value !== want.scaled_value)
                    report_mismatch("scaled_value", result_ch.scaled_value, want.scaled_value);
                if (want.keep) kept_count++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // reset defaults: one index, unit scale
    task automatic test_reset_defaults();
        send_entry(32'd0, 32'h0001_0000);
        send_entry(32'hFFFF_FFFF, 32'h8000_0000);
        send_entry(32'd7, 32'h7FFF_FFFF);
    endtask

    // plain transpose with open indices
    task automatic test_open_transpose();
        configure(32'h0203_0405, 8'h00, {32'd1, 32'd20}, {32'd5, 32'd60}, 32'h0001_0000, 3'd4);
        send_entry(32'd0, 32'd1);
        send_entry(32'd119, 32'hFFFF_FFFF);
        send_entry(32'd120, 32'd12345);
        send_entry(32'hFFFF_FFFF, 32'h8000_0000);
        send_entry(32'd57, 32'h7FFF_FFFF);
    endtask

    // fixed, trace, out-of-range partner, zero dims, code 3 as open
    task automatic test_fixed_trace();
        configure(32'h0304_0003, 8'b11_10_10_01, {32'd3, 32'd2}, {32'd9, 32'd7},
                  32'h8000_0000, 3'd4);
        for (int p = 0; p < 12; p++) send_entry(32'(p * 5 + 2), $urandom());
        configure(32'h0000_0000, 8'b01_01_01_01, {32'hFFFF_FFFF, 32'd0}, 64'd0,
                  32'h7FFF_FFFF, 3'd0);
        send_entry(32'd5, 32'h7FFF_FFFF);
        send_entry(32'd6, 32'h8000_0000);
        configure(32'hFF01_FFFF, 8'b00_10_10_00, {32'd4, 32'hFFFF_FFFF}, {32'd0, 32'd1},
                  32'hFFFF_FFFF, 3'd7);
        send_entry(32'hFFFF_FFFF, 32'h0000_8000);
        send_entry(32'h0001_0001, 32'hFFFF_8000);
    endtask

    // random configs, mostly small dims so checks pass often
    task automatic test_random_mix();
        logic [31:0] dims;
        logic [63:0] lo;
        logic [63:0] hi;
        bit wide;
        for (int phase = 0; phase < 14; phase++) begin
            wide = (phase % 4 == 3);
            for (int i = 0; i < 4; i++)
                dims[8*i +: 8] = wide ? 8'($urandom()) : 8'($urandom_range(0, 6));
            lo = {32'($urandom_range(0, 4)), 32'($urandom_range(0, 4))};
            hi = {32'($urandom_range(0, 4)), 32'($urandom_range(0, 4))};
            if (wide) begin
                lo = {$urandom(), $urandom()};
                hi = {$urandom(), $urandom()};
            end
            configure(dims, 8'($urandom()), lo, hi,
                      (phase % 3 == 0) ? $urandom() : 32'($urandom_range(0, 1 << 18)),
                      3'($urandom()));
            send_random(45, !wide);
            if (phase == 6) begin
                // hold off until everything is back
                entry_ch.valid <= 1'b0;
                while (remap_queue.size() != 0) @(posedge i_clk);
                recv_hold = 1'b1;
            end
        end
        recv_hold = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = stir_pkg::CFG_DIMS;
        i_cfg_data = '0;
        entry_ch.valid = 1'b0;
        entry_ch.entry_position = '0;
        entry_ch.entry_value = '0;
        result_ch.ready = 1'b0;
        recv_hold = 1'b0;
        error_count = 0;
        result_count = 0;
        kept_count = 0;
        entries_sent = 0;
        dims_q = stir_pkg::DIMS_RST;
        kinds_q = '0;
        attrs_lo_q = '0;
        attrs_hi_q = '0;
        scale_q = stir_pkg::SCALE_RST;
        degree_q = stir_pkg::DEGREE_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_open_transpose();
        test_fixed_trace();
        test_random_mix();

        drain();
        $display("sent %0d entries, checked %0d results, %0d kept", entries_sent,
                 result_count, kept_count);
        $display("covered open, fixed, trace, zero dims, degree clamp, saturation");
        if (error_count == 0 && remap_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d errors, %0d results missing", error_count, remap_queue.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
